@@ hdl/lav_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lav_pkg
// Types and constants shared by the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

   localparam int NORM_W = 50;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] tgt_x;
      logic signed [31:0] tgt_y;
      logic signed [31:0] tgt_z;
      logic signed [31:0] up_x;
      logic signed [31:0] up_y;
      logic signed [31:0] up_z;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] elem_a;
      logic signed [31:0] elem_b;
      logic signed [31:0] elem_c;
      logic signed [31:0] elem_d;
      logic               last_row;
   } rsp_word_type;

   typedef logic [2:0][31:0]       word3_type;
   typedef logic [2:0][NORM_W-1:0] wide3_type;
   typedef logic [2:0][63:0]       prod3_type;

   // Position plus two vectors that ride along with the arithmetic.
   typedef struct packed {
      word3_type p;
      word3_type a;
      word3_type b;
   } side_type;

   localparam logic [1:0] ROW_LEFT  = 2'd0;
   localparam logic [1:0] ROW_UP    = 2'd1;
   localparam logic [1:0] ROW_FWD   = 2'd2;
   localparam logic [1:0] ROW_CONST = 2'd3;

   localparam logic [31:0] ONE_Q16 = 32'd65536;

   function automatic logic [63:0] smul32(input logic [31:0] a, input logic [31:0] b);
      logic signed [63:0] r;
      r = $signed(a) * $signed(b);
      return r;
   endfunction

endpackage
`default_nettype wire

@@ hdl/look_at_view_matrix.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Look-at view matrix in signed Q16.16, emitted one row per result word.
// ----------------------------------------------------------------------------
//  channel  direction  word                      handshake
//  req_     in         position, target, up      req_valid / req_stall
//  rsp_     out        row index, 4 elems, last  rsp_valid / rsp_stall
//
// One camera word yields four row words; the row serializer sets the rate, and
// the pipeline advances only when no matrix is held or its constant row is taken.
// Most of the pipeline depth lies in the two normalizers
// (32 square root stages and 17 divider stages each).
// Reset clears all valid bits; payload registers are not reset.
// While rows 0 to 2 are being sent, or the result side stalls, the whole
// pipeline holds and req_stall is high.
module look_at_view_matrix (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lav_pkg::req_word_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lav_pkg::rsp_word_type  rsp_data
);
   import lav_pkg::*;

   logic      en;
   logic      s0_v_ff;
   wide3_type s0_fd_ff, fd_in;
   side_type  s0_side_ff, s0_side_in;
   logic      n1_v, c1_v, n2_v, c2_v;
   word3_type f_vec, l_vec;
   side_type  n1_side, c1_in_side, c1_side, n2_in_side, n2_side, c2_in_side, c2_side;
   prod3_type lf_prod, uf_prod;
   wide3_type lf_vec;
   word3_type pos_w, tgt_w, up_w;

   assign pos_w = {req_data.pos_z, req_data.pos_y, req_data.pos_x};
   assign tgt_w = {req_data.tgt_z, req_data.tgt_y, req_data.tgt_x};
   assign up_w  = {req_data.up_z, req_data.up_y, req_data.up_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fd_in[i] = {{(NORM_W-32){pos_w[i][31]}}, pos_w[i]}
                  - {{(NORM_W-32){tgt_w[i][31]}}, tgt_w[i]};
         lf_vec[i] = lf_prod[i][NORM_W-1:0];
      end
      s0_side_in.p = pos_w;
      s0_side_in.a = up_w;
      s0_side_in.b = '0;
   end

   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_fd_ff   <= fd_in;
         s0_side_ff <= s0_side_in;
      end
   end

   // Forward axis.
   lav_norm u_norm_f (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s0_v_ff), .in_vec(s0_fd_ff), .in_side(s0_side_ff),
      .out_valid(n1_v), .out_vec(f_vec), .out_side(n1_side)
   );

   assign c1_in_side = '{p: n1_side.p, a: n1_side.a, b: f_vec};

   lav_cross u_cross_l (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(n1_v), .in_side(c1_in_side),
      .out_valid(c1_v), .out_prod(lf_prod), .out_side(c1_side)
   );

   assign n2_in_side = '{p: c1_side.p, a: c1_side.b, b: '0};

   // Left axis.
   lav_norm u_norm_l (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(c1_v), .in_vec(lf_vec), .in_side(n2_in_side),
      .out_valid(n2_v), .out_vec(l_vec), .out_side(n2_side)
   );

   assign c2_in_side = '{p: n2_side.p, a: n2_side.a, b: l_vec};

   lav_cross u_cross_u (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(n2_v), .in_side(c2_in_side),
      .out_valid(c2_v), .out_prod(uf_prod), .out_side(c2_side)
   );

   lav_out u_out (
      .clock(clock), .reset(reset),
      .in_valid(c2_v), .in_prod(uf_prod), .in_side(c2_side),
      .en(en),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire

@@ hdl/lav_norm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined vector normalizer: magnitude alignment, sum of squares,
// one square root step per stage, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lav_norm (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  lav_pkg::wide3_type in_vec,
   input  lav_pkg::side_type  in_side,
   output logic              out_valid,
   output lav_pkg::word3_type out_vec,
   output lav_pkg::side_type  out_side
);
   import lav_pkg::*;

   localparam int SQ_STEPS = 32;
   localparam int DV_STEPS = 17;
   localparam logic [5:0] TOP_BIT = 6'd30;

   typedef struct packed {
      logic [2:0][30:0] mag;
      logic [2:0]       neg;
      logic             zero;
      side_type         side;
   } carry_type;

   logic                   v1_ff, v2_ff, v3_ff;
   logic [2:0][NORM_W-1:0] m1_ff, m1_in;
   logic [2:0]             neg1_ff, neg1_in;
   logic [5:0]             pos1_ff, pos1_in;
   logic                   zero1_ff, zero1_in;
   side_type               side1_ff;
   logic [NORM_W-1:0]      ormag;
   carry_type              c2_ff, c2_in, c3_ff;
   logic [2:0][61:0]       sq3_ff, sq3_in;

   logic [SQ_STEPS:0]      sq_v_ff;
   logic [63:0]            sq_s_ff [SQ_STEPS+1];
   logic [63:0]            sq_s_in [SQ_STEPS+1];
   logic [63:0]            sq_r_ff [SQ_STEPS+1];
   logic [63:0]            sq_r_in [SQ_STEPS+1];
   carry_type              sq_c_ff [SQ_STEPS+1];
   carry_type              sq_c_in [SQ_STEPS+1];

   logic [DV_STEPS:0]      dv_v_ff;
   logic [2:0][32:0]       dv_rem_ff [DV_STEPS+1];
   logic [2:0][32:0]       dv_rem_in [DV_STEPS+1];
   logic [2:0][16:0]       dv_q_ff [DV_STEPS+1];
   logic [2:0][16:0]       dv_q_in [DV_STEPS+1];
   logic [31:0]            dv_len_ff [DV_STEPS+1];
   logic [31:0]            dv_len_in [DV_STEPS+1];
   carry_type              dv_c_ff [DV_STEPS+1];
   carry_type              dv_c_in [DV_STEPS+1];

   // Stage 1: magnitudes and the top set bit of their OR, which is the top bit of the largest.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = in_vec[i][NORM_W-1];
         m1_in[i]   = in_vec[i][NORM_W-1] ? (~in_vec[i] + NORM_W'(1)) : in_vec[i];
      end
      ormag = m1_in[0] | m1_in[1] | m1_in[2];
      pos1_in = '0;
      for (int b = 0; b < NORM_W; b++) begin
         if (ormag[b]) pos1_in = 6'(b);
      end
      zero1_in = (ormag == '0);
   end

   // Stage 2: align so the largest magnitude has its top bit at bit 30.
   always_comb begin
      logic [NORM_W-1:0] sh;
      c2_in.neg  = neg1_ff;
      c2_in.zero = zero1_ff;
      c2_in.side = side1_ff;
      for (int i = 0; i < 3; i++) begin
         if (pos1_ff > TOP_BIT) begin
            sh = m1_ff[i] >> (pos1_ff - TOP_BIT);
         end else begin
            sh = m1_ff[i] << (TOP_BIT - pos1_ff);
         end
         c2_in.mag[i] = sh[30:0];
      end
   end

   // Stage 3: squares.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq3_in[i] = 62'(c2_ff.mag[i]) * 62'(c2_ff.mag[i]);
      end
   end

   // Square root, one result bit per stage.
   always_comb begin
      logic [64:0] trial;
      sq_s_in[0] = 64'(sq3_ff[0]) + 64'(sq3_ff[1]) + 64'(sq3_ff[2]);
      sq_r_in[0] = '0;
      sq_c_in[0] = c3_ff;
      for (int i = 0; i < SQ_STEPS; i++) begin
         sq_c_in[i+1] = sq_c_ff[i];
         trial = {1'b0, sq_r_ff[i]} + (65'd1 << (2*SQ_STEPS - 2 - 2*i));
         if ({1'b0, sq_s_ff[i]} >= trial) begin
            sq_s_in[i+1] = sq_s_ff[i] - trial[63:0];
            sq_r_in[i+1] = (sq_r_ff[i] >> 1) + (64'd1 << (2*SQ_STEPS - 2 - 2*i));
         end else begin
            sq_s_in[i+1] = sq_s_ff[i];
            sq_r_in[i+1] = sq_r_ff[i] >> 1;
         end
      end
   end

   // Restoring division of (mag << 16) by the length, one quotient bit per stage.
   // Each magnitude is at most the length, so the quotient has 17 bits.
   always_comb begin
      logic [31:0] len0;
      logic [32:0] trial_d;
      len0 = sq_r_ff[SQ_STEPS][31:0];
      if (len0 == '0) len0 = 32'd1;
      dv_len_in[0] = len0;
      dv_c_in[0]   = sq_c_ff[SQ_STEPS];
      dv_q_in[0]   = '0;
      for (int i = 0; i < 3; i++) begin
         dv_rem_in[0][i] = {3'b000, sq_c_ff[SQ_STEPS].mag[i][30:1]};
      end
      for (int j = 0; j < DV_STEPS; j++) begin
         dv_len_in[j+1] = dv_len_ff[j];
         dv_c_in[j+1]   = dv_c_ff[j];
         dv_q_in[j+1]   = dv_q_ff[j];
         for (int i = 0; i < 3; i++) begin
            trial_d = {dv_rem_ff[j][i][31:0], (j == 0) ? dv_c_ff[j].mag[i][0] : 1'b0};
            if (trial_d >= {1'b0, dv_len_ff[j]}) begin
               dv_rem_in[j+1][i] = trial_d - {1'b0, dv_len_ff[j]};
               dv_q_in[j+1][i][DV_STEPS-1-j] = 1'b1;
            end else begin
               dv_rem_in[j+1][i] = trial_d;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         sq_v_ff <= '0;
         dv_v_ff <= '0;
      end else if (en) begin
         v1_ff   <= in_valid;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         sq_v_ff <= {sq_v_ff[SQ_STEPS-1:0], v3_ff};
         dv_v_ff <= {dv_v_ff[DV_STEPS-1:0], sq_v_ff[SQ_STEPS]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff    <= m1_in;
         neg1_ff  <= neg1_in;
         pos1_ff  <= pos1_in;
         zero1_ff <= zero1_in;
         side1_ff <= in_side;
         c2_ff    <= c2_in;
         c3_ff    <= c2_ff;
         sq3_ff   <= sq3_in;
         for (int i = 0; i <= SQ_STEPS; i++) begin
            sq_s_ff[i] <= sq_s_in[i];
            sq_r_ff[i] <= sq_r_in[i];
            sq_c_ff[i] <= sq_c_in[i];
         end
         for (int j = 0; j <= DV_STEPS; j++) begin
            dv_rem_ff[j] <= dv_rem_in[j];
            dv_q_ff[j]   <= dv_q_in[j];
            dv_len_ff[j] <= dv_len_in[j];
            dv_c_ff[j]   <= dv_c_in[j];
         end
      end
   end

   always_comb begin
      logic [31:0] q;
      for (int i = 0; i < 3; i++) begin
         q = {15'd0, dv_q_ff[DV_STEPS][i]};
         if (dv_c_ff[DV_STEPS].zero) begin
            out_vec[i] = '0;
         end else if (dv_c_ff[DV_STEPS].neg[i]) begin
            out_vec[i] = ~q + 32'd1;
         end else begin
            out_vec[i] = q;
         end
      end
   end

   assign out_valid = dv_v_ff[DV_STEPS];
   assign out_side  = dv_c_ff[DV_STEPS].side;

endmodule
`default_nettype wire

@@ hdl/lav_cross.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lav_cross
// Two-stage cross product a x b of the vectors carried in the side word.
// ----------------------------------------------------------------------------
module lav_cross (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  lav_pkg::side_type  in_side,
   output logic              out_valid,
   output lav_pkg::prod3_type out_prod,
   output lav_pkg::side_type  out_side
);
   import lav_pkg::*;

   logic             v1_ff, v2_ff;
   logic [5:0][63:0] pr_ff, pr_in;
   side_type         side1_ff, side2_ff;
   prod3_type        cr_ff, cr_in;

   always_comb begin
      pr_in[0] = smul32(in_side.a[1], in_side.b[2]);
      pr_in[1] = smul32(in_side.a[2], in_side.b[1]);
      pr_in[2] = smul32(in_side.a[2], in_side.b[0]);
      pr_in[3] = smul32(in_side.a[0], in_side.b[2]);
      pr_in[4] = smul32(in_side.a[0], in_side.b[1]);
      pr_in[5] = smul32(in_side.a[1], in_side.b[0]);
      cr_in[0] = pr_ff[0] - pr_ff[1];
      cr_in[1] = pr_ff[2] - pr_ff[3];
      cr_in[2] = pr_ff[4] - pr_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pr_ff    <= pr_in;
         side1_ff <= in_side;
         cr_ff    <= cr_in;
         side2_ff <= side1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_prod  = cr_ff;
   assign out_side  = side2_ff;

endmodule
`default_nettype wire

@@ hdl/lav_out.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lav_out
// Translation dot products and the row serializer that drives the result
// channel; it also produces the advance enable for the whole pipeline.
// ----------------------------------------------------------------------------
module lav_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  lav_pkg::prod3_type   in_prod,
   input  lav_pkg::side_type    in_side,
   output logic                en,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lav_pkg::rsp_word_type rsp_data
);
   import lav_pkg::*;

   localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
   localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

   function automatic logic [31:0] neg_dot(input prod3_type pr);
      logic signed [63:0] sum;
      logic signed [63:0] sh;
      logic [31:0]        r;
      sum = $signed(pr[0]) + $signed(pr[1]) + $signed(pr[2]);
      sh  = (-sum) >>> 16;
      if (sh > SAT_HI) begin
         r = SAT_HI[31:0];
      end else if (sh < SAT_LO) begin
         r = SAT_LO[31:0];
      end else begin
         r = sh[31:0];
      end
      return r;
   endfunction

   logic       d1_v_ff;
   word3_type  d1_l_ff, d1_u_ff, d1_f_ff, up_in;
   prod3_type  d1_pl_ff, d1_pu_ff, d1_pf_ff, pl_in, pu_in, pf_in;
   logic       ser_v_ff;
   logic [1:0] ser_row_ff;
   word3_type  ser_l_ff, ser_u_ff, ser_f_ff;
   word3_type  ser_d_ff;
   logic       take;

   always_comb begin
      logic signed [63:0] t;
      for (int i = 0; i < 3; i++) begin
         t        = $signed(in_prod[i]) >>> 16;
         up_in[i] = t[31:0];
         pl_in[i] = smul32(in_side.b[i], in_side.p[i]);
         pu_in[i] = smul32(up_in[i], in_side.p[i]);
         pf_in[i] = smul32(in_side.a[i], in_side.p[i]);
      end
   end

   assign take = ser_v_ff && !rsp_stall;
   // A new matrix loads when none is held or once the constant row of the current one is taken.
   assign en   = !ser_v_ff || (take && ser_row_ff == ROW_CONST);

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_v_ff    <= 1'b0;
         ser_v_ff   <= 1'b0;
         ser_row_ff <= ROW_LEFT;
      end else if (en) begin
         d1_v_ff    <= in_valid;
         ser_v_ff   <= d1_v_ff;
         ser_row_ff <= ROW_LEFT;
      end else if (take) begin
         ser_row_ff <= ser_row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_l_ff     <= in_side.b;
         d1_u_ff     <= up_in;
         d1_f_ff     <= in_side.a;
         d1_pl_ff    <= pl_in;
         d1_pu_ff    <= pu_in;
         d1_pf_ff    <= pf_in;
         ser_l_ff    <= d1_l_ff;
         ser_u_ff    <= d1_u_ff;
         ser_f_ff    <= d1_f_ff;
         ser_d_ff[0] <= neg_dot(d1_pl_ff);
         ser_d_ff[1] <= neg_dot(d1_pu_ff);
         ser_d_ff[2] <= neg_dot(d1_pf_ff);
      end
   end

   always_comb begin
      rsp_data.row_index = ser_row_ff;
      rsp_data.last_row  = 1'b0;
      case (ser_row_ff)
         ROW_LEFT: begin
            rsp_data.elem_a = ser_l_ff[0];
            rsp_data.elem_b = ser_l_ff[1];
            rsp_data.elem_c = ser_l_ff[2];
            rsp_data.elem_d = ser_d_ff[0];
         end
         ROW_UP: begin
            rsp_data.elem_a = ser_u_ff[0];
            rsp_data.elem_b = ser_u_ff[1];
            rsp_data.elem_c = ser_u_ff[2];
            rsp_data.elem_d = ser_d_ff[1];
         end
         ROW_FWD: begin
            rsp_data.elem_a = ser_f_ff[0];
            rsp_data.elem_b = ser_f_ff[1];
            rsp_data.elem_c = ser_f_ff[2];
            rsp_data.elem_d = ser_d_ff[2];
         end
         default: begin
            rsp_data.elem_a   = '0;
            rsp_data.elem_b   = '0;
            rsp_data.elem_c   = '0;
            rsp_data.elem_d   = ONE_Q16;
            rsp_data.last_row = 1'b1;
         end
      endcase
   end

   assign rsp_valid = ser_v_ff;

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Look-at view matrix testbench
// Drives camera words with random gaps, predicts the four matrix rows of each
// one with an independent fixed-point model, and checks every row word in order.
// ----------------------------------------------------------------------------
module tb;
   import lav_pkg::*;

   localparam int LATENCY    = 200;
   localparam int CYCLE_CAP  = 1000000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_data;

   rsp_word_type rows_due[$];
   int           fail_count;
   int           cycle_count;
   bit           rsp_idle_on;

   look_at_view_matrix i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint floor_shift(longint x, int sh);
      return x >>> sh;
   endfunction

   function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint unsigned root64(longint unsigned s);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Scales the magnitudes so the largest sits in [2^30, 2^31) before the root.
   task automatic unit_vector(input longint v[3], output longint r[3]);
      longint unsigned m[3];
      longint unsigned mx;
      longint unsigned sq;
      longint unsigned len;
      longint q;
      mx = 0;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         for (int i = 0; i < 3; i++) r[i] = 0;
         return;
      end
      while (mx >= (64'd1 << 31)) begin
         for (int i = 0; i < 3; i++) m[i] >>= 1;
         mx >>= 1;
      end
      while (mx < (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] <<= 1;
         mx <<= 1;
      end
      for (int i = 0; i < 3; i++) sq += m[i] * m[i];
      len = root64(sq);
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) begin
         q = longint'((m[i] << 16) / len);
         r[i] = (v[i] < 0) ? -q : q;
      end
   endtask

   function automatic logic [31:0] translation(longint a[3], longint p[3]);
      longint sum;
      sum = a[0] * p[0] + a[1] * p[1] + a[2] * p[2];
      return 32'(clamp32(floor_shift(-sum, 16)));
   endfunction

   task automatic predict_view(input req_word_type w);
      longint p[3], t[3], u[3], fd[3], f[3], lf[3], l[3], up[3];
      rsp_word_type r;
      p = '{longint'(w.pos_x), longint'(w.pos_y), longint'(w.pos_z)};
      t = '{longint'(w.tgt_x), longint'(w.tgt_y), longint'(w.tgt_z)};
      u = '{longint'(w.up_x), longint'(w.up_y), longint'(w.up_z)};
      for (int i = 0; i < 3; i++) fd[i] = p[i] - t[i];
      unit_vector(fd, f);
      lf[0] = u[1] * f[2] - u[2] * f[1];
      lf[1] = u[2] * f[0] - u[0] * f[2];
      lf[2] = u[0] * f[1] - u[1] * f[0];
      unit_vector(lf, l);
      up[0] = floor_shift(f[1] * l[2] - f[2] * l[1], 16);
      up[1] = floor_shift(f[2] * l[0] - f[0] * l[2], 16);
      up[2] = floor_shift(f[0] * l[1] - f[1] * l[0], 16);
      r = '{ROW_LEFT, 32'(l[0]), 32'(l[1]), 32'(l[2]), translation(l, p), 1'b0};
      rows_due.push_back(r);
      r = '{ROW_UP, 32'(up[0]), 32'(up[1]), 32'(up[2]), translation(up, p), 1'b0};
      rows_due.push_back(r);
      r = '{ROW_FWD, 32'(f[0]), 32'(f[1]), 32'(f[2]), translation(f, p), 1'b0};
      rows_due.push_back(r);
      r = '{ROW_CONST, 32'd0, 32'd0, 32'd0, ONE_Q16, 1'b1};
      rows_due.push_back(r);
   endtask

   // Valid stays high from one word to the next unless a gap is drawn.
   task automatic send_camera(input req_word_type w, input bit gaps);
      int wait_cycles;
      wait_cycles = gaps ? $urandom_range(0, 10) : 0;
      if (wait_cycles > 0) begin
         req_valid <= 1'b0;
         repeat (wait_cycles) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_view(w);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (rows_due.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 20'sh80000);
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         3: return 32'($signed($urandom_range(0, 16'hFFFF)) - 16'sh8000);
         default: return 32'($signed($urandom_range(0, 24'hFFFFFF)) - 24'sh800000);
      endcase
   endfunction

   function automatic req_word_type rand_camera();
      req_word_type w;
      w = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      // Some words share the target with the position, others a parallel up.
      if ($urandom_range(0, 15) == 0) {w.tgt_x, w.tgt_y, w.tgt_z} =
         {w.pos_x, w.pos_y, w.pos_z};
      if ($urandom_range(0, 15) == 0) {w.up_x, w.up_y, w.up_z} =
         {w.pos_x - w.tgt_x, w.pos_y - w.tgt_y, w.pos_z - w.tgt_z};
      return w;
   endfunction

   task automatic test_directed();
      logic [31:0] mx, mn;
      mx = 32'h7FFFFFFF;
      mn = 32'h80000000;
      rsp_idle_on = 1'b0;
      // Plain camera on the z axis with y up.
      send_camera('{0, 0, 32'h50000, 0, 0, 0, 0, 32'h10000, 0}, 1'b0);
      // Position equal to target leaves a zero forward axis.
      send_camera('{32'h10000, 32'h20000, 32'h30000, 32'h10000, 32'h20000,
                    32'h30000, 0, 32'h10000, 0}, 1'b0);
      // Up parallel to forward gives a zero left axis.
      send_camera('{0, 0, 32'h50000, 0, 0, 0, 0, 0, 32'h10000}, 1'b0);
      send_camera('{0, 0, 32'h50000, 0, 0, 0, 0, 0, 0}, 1'b0);
      send_camera('{mx, mx, mx, mn, mn, mn, mx, mn, mx}, 1'b1);
      send_camera('{mn, mn, mn, mx, mx, mx, mn, mx, mn}, 1'b1);
      send_camera('{mx, mn, mx, mn, mx, mn, mn, mn, mn}, 1'b1);
      send_camera('{mn, 0, 0, 0, 0, 0, 0, mx, 0}, 1'b1);
      send_camera('{mx, mx, mx, 0, 0, 0, 0, 0, 1}, 1'b1);
      send_camera('{1, 0, 0, 0, 0, 0, 0, 1, 0}, 1'b1);
      send_camera('{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0,
                    32'hFFFFFFFF, 0, 1}, 1'b1);
      send_camera('{32'h12345678, 32'hEDCBA987, 32'h0F0F0F0F, 32'hF0F0F0F0,
                    32'h55555555, 32'hAAAAAAAA, 32'h33333333, 32'hCCCCCCCC,
                    32'h01010101}, 1'b1);
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) begin
         // Let the pipeline drain fully once, halfway through.
         if (n == count / 2) wait_drained();
         rsp_idle_on = (n % 100) < 70;
         send_camera(rand_camera(), (n % 100) < 70 || n % 100 >= 85);
      end
      rsp_idle_on = 1'b1;
   endtask

   // Result side: random stall per word, sampled at the rising edge.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         hold = (rsp_idle_on && !reset) ? $urandom_range(0, 10) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_word_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rows_due.size() == 0) begin
            $error("row word with nothing expected: %p", rsp_data);
            fail_count++;
         end else begin
            due = rows_due.pop_front();
            if (rsp_data.row_index !== due.row_index) begin
               $error("row_index expected %0d actual %0d", due.row_index,
                      rsp_data.row_index);
               fail_count++;
            end
            if (rsp_data.elem_a !== due.elem_a) begin
               $error("elem_a expected %0d actual %0d", due.elem_a, rsp_data.elem_a);
               fail_count++;
            end
            if (rsp_data.elem_b !== due.elem_b) begin
               $error("elem_b expected %0d actual %0d", due.elem_b, rsp_data.elem_b);
               fail_count++;
            end
            if (rsp_data.elem_c !== due.elem_c) begin
               $error("elem_c expected %0d actual %0d", due.elem_c, rsp_data.elem_c);
               fail_count++;
            end
            if (rsp_data.elem_d !== due.elem_d) begin
               $error("elem_d expected %0d actual %0d", due.elem_d, rsp_data.elem_d);
               fail_count++;
            end
            if (rsp_data.last_row !== due.last_row) begin
               $error("last_row expected %0d actual %0d", due.last_row,
                      rsp_data.last_row);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      fail_count = 0;
      cycle_count = 0;
      rsp_idle_on = 1'b1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(460);
      wait_drained();
      repeat (LATENCY) @(negedge clock);
      if (fail_count == 0 && rows_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
